// ===== rtl/mtos_pkg.sv =====
package mtos_pkg;

    localparam int NV = 8;
    localparam int VW = 3;
    localparam int HM = 16;
    localparam int HW = 4;
    localparam int LW = 5;
    localparam int IW = 4;

    localparam logic [LW-1:0] HIST_LEN_RESET = 5'd10;
    localparam logic [LW-1:0] HIST_LEN_MIN   = 5'd2;
    localparam logic [LW-1:0] HIST_LEN_MAX   = 5'd16;

    localparam logic [1:0] CMD_REPORT = 2'd0;
    localparam logic [1:0] CMD_TRIP   = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] KIND_SPEED = 2'd0;
    localparam logic [1:0] KIND_ODO   = 2'd1;
    localparam logic [1:0] KIND_TRIP  = 2'd2;

    localparam logic [2:0] ADDR_HIST_LEN = 3'd0;

    localparam logic [31:0] M32 = 32'hFFFF_FFFF;
    localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [32:0] MS_PER_S = 33'd1000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] t;
    } t_hist;

endpackage

// ===== rtl/multi_track_odometer_speed.sv =====
// A position report adds a leg to the odometers (not for a track's first
// report); a tick walks every track, computing each leg of a speed report
// (a leg with zero elapsed time skips its divide); output stalls add delay.
// Throughput: one transfer at a time; input stalls until the item is done.
// Reset (sync, active low) clears odometers, counts and marks, sets history
// length to 10; the history memory is not cleared.
module multi_track_odometer_speed import mtos_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [2:0]         i_vehicle,
    input  logic signed [31:0] i_x_pos,
    input  logic signed [31:0] i_y_pos,
    input  logic [31:0]        i_time_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic [2:0]         o_track,
    output logic [31:0]        o_mean_spd,
    output logic [47:0]        o_odo_total,
    output logic [47:0]        o_odo_trip,
    output logic               o_reset_ok,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_RLA, S_SQX, S_SQY, S_SQRT, S_RADD, S_RWR, S_TRIP,
        S_TTRK, S_TLA, S_TLB, S_TDT, S_TMUL, S_DIV, S_TACC, S_TAVG, S_TEMIT,
        S_OSCAN
    } t_state;

    t_state r_state;

    t_hist r_mem [NV*HM];
    t_hist r_rd;
    t_hist r_a;
    t_hist r_b;

    logic [LW-1:0] r_hist_len;
    logic [LW-1:0] r_cnt  [NV];
    logic [HW-1:0] r_head [NV];
    logic [47:0]   r_total [NV];
    logic [47:0]   r_trip  [NV];
    logic [NV-1:0] r_changed;
    logic [NV-1:0] r_known;

    logic [1:0]    r_cmd;
    logic [VW-1:0] r_v;
    logic [31:0]   r_x;
    logic [31:0]   r_y;
    logic [31:0]   r_t;

    logic          r_mode_tick;
    logic          r_div_avg;
    logic [IW-1:0] r_i;
    logic [HW-1:0] r_idx;
    logic [HW-1:0] r_legs;
    logic [HW-1:0] r_nlegs;
    logic [35:0]   r_sum;
    logic [31:0]   r_spd;
    logic [5:0]    r_step;

    logic [65:0]   r_rad;
    logic [35:0]   r_srem;
    logic [32:0]   r_root;
    logic [47:0]   r_dvd;
    logic [31:0]   r_dvs;
    logic [31:0]   r_rem;

    logic          r_ov;
    logic [1:0]    r_o_kind;
    logic [VW-1:0] r_o_track;
    logic [31:0]   r_o_spd;
    logic [47:0]   r_o_total;
    logic [47:0]   r_o_trip;
    logic          r_o_ok;
    logic          r_o_last;

    logic [LW-1:0] eff_len;
    logic [VW-1:0] ti;
    logic [LW-1:0] t_c;
    logic [HW-1:0] t_nl;
    logic [HW-1:0] t_idx0;
    logic [NV-1:0] spd_has;
    logic          more_spd;
    logic          more_chg;
    logic          slot_free;
    logic          out_load;
    logic [31:0]   dx;
    logic [31:0]   dy;
    logic [32:0]   mul_a;
    logic [32:0]   mul_b;
    logic [65:0]   prod;
    logic [35:0]   s_rem;
    logic [35:0]   s_trial;
    logic          s_ok;
    logic [32:0]   d_t;
    logic          d_ok;
    logic [31:0]   d_rem;
    logic [47:0]   d_q;
    logic [31:0]   dt;
    logic [48:0]   sum_tot;
    logic [48:0]   sum_trip;
    logic [LW:0]   cnt_inc;
    logic [HW-1:0] head_nx;
    logic [6:0]    rd_addr;
    logic          cfg_we;

    always_comb begin
        if (r_hist_len < HIST_LEN_MIN) begin
            eff_len = HIST_LEN_MIN;
        end else if (r_hist_len > HIST_LEN_MAX) begin
            eff_len = HIST_LEN_MAX;
        end else begin
            eff_len = r_hist_len;
        end
    end

    assign ti      = r_i[VW-1:0];
    assign t_c     = (r_cnt[ti] < eff_len) ? r_cnt[ti] : eff_len;
    assign t_nl    = HW'(t_c - 5'd1);
    assign t_idx0  = r_head[ti] - t_nl;
    assign head_nx = r_head[r_v] + 4'd1;
    assign cnt_inc = {1'b0, r_cnt[r_v]} + 6'd1;

    always_comb begin
        for (int j = 0; j < NV; j++) begin
            spd_has[j] = (((r_cnt[j] < eff_len) ? r_cnt[j] : eff_len) > 5'd1);
        end
        more_spd = 1'b0;
        more_chg = 1'b0;
        for (int j = 0; j < NV; j++) begin
            if (j > int'(r_i)) begin
                more_spd = more_spd | spd_has[j];
                more_chg = more_chg | r_changed[j];
            end
        end
    end

    assign slot_free = !r_ov || !i_out_stall;

    always_comb begin
        unique case (r_state)
            S_TRIP, S_TEMIT: out_load = slot_free;
            S_OSCAN:         out_load = slot_free && (r_i != IW'(NV)) && r_changed[ti];
            default:         out_load = 1'b0;
        endcase
    end

    assign dx = ($signed(r_a.x) >= $signed(r_b.x)) ? r_a.x - r_b.x : r_b.x - r_a.x;
    assign dy = ($signed(r_a.y) >= $signed(r_b.y)) ? r_a.y - r_b.y : r_b.y - r_a.y;

    always_comb begin
        unique case (r_state)
            S_SQX: begin
                mul_a = {1'b0, dx};
                mul_b = {1'b0, dx};
            end
            S_SQY: begin
                mul_a = {1'b0, dy};
                mul_b = {1'b0, dy};
            end
            default: begin
                mul_a = r_root;
                mul_b = MS_PER_S;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign s_rem   = {r_srem[33:0], r_rad[65:64]};
    assign s_trial = {1'b0, r_root, 2'b01};
    assign s_ok    = (s_rem >= s_trial);

    assign d_t   = {r_rem, r_dvd[47]};
    assign d_ok  = (d_t >= {1'b0, r_dvs});
    assign d_rem = d_ok ? 32'(d_t - {1'b0, r_dvs}) : d_t[31:0];
    assign d_q   = {r_dvd[46:0], d_ok};

    assign dt = r_b.t - r_a.t;

    assign sum_tot  = {1'b0, r_total[r_v]} + {16'd0, r_root};
    assign sum_trip = {1'b0, r_trip[r_v]}  + {16'd0, r_root};

    always_comb begin
        unique case (r_state)
            S_DISP:         rd_addr = {r_v, r_head[r_v]};
            S_TTRK:         rd_addr = {ti, t_idx0};
            S_TLA, S_TACC:  rd_addr = {ti, r_idx + 4'd1};
            default:        rd_addr = {ti, r_idx};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RWR) begin
            r_mem[{r_v, head_nx}] <= '{x: r_x, y: r_y, t: r_t};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign cfg_we = psel && penable && pwrite && (paddr == ADDR_HIST_LEN);
    assign prdata = (paddr == ADDR_HIST_LEN) ? {27'd0, r_hist_len} : 32'd0;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hist_len  <= HIST_LEN_RESET;
            r_changed   <= '0;
            r_known     <= '0;
            r_ov        <= 1'b0;
            r_i         <= '0;
            for (int j = 0; j < NV; j++) begin
                r_cnt[j]   <= '0;
                r_head[j]  <= '0;
                r_total[j] <= '0;
                r_trip[j]  <= '0;
            end
        end else begin
            if (cfg_we) begin
                r_hist_len <= pwdata[LW-1:0];
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_cmd;
                        r_v     <= i_vehicle;
                        r_x     <= i_x_pos;
                        r_y     <= i_y_pos;
                        r_t     <= i_time_ms;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    case (r_cmd)
                        CMD_REPORT: begin
                            r_mode_tick <= 1'b0;
                            r_state     <= (r_cnt[r_v] != '0) ? S_RLA : S_RWR;
                        end
                        CMD_TRIP: r_state <= S_TRIP;
                        CMD_TICK: begin
                            r_mode_tick <= 1'b1;
                            r_i         <= '0;
                            r_state     <= S_TTRK;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_RLA: begin
                    r_a     <= r_rd;
                    r_b.x   <= r_x;
                    r_b.y   <= r_y;
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_rad   <= prod;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_rad   <= r_rad + prod;
                    r_srem  <= '0;
                    r_root  <= '0;
                    r_step  <= 6'd33;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_srem <= s_ok ? s_rem - s_trial : s_rem;
                    r_root <= {r_root[31:0], s_ok};
                    r_rad  <= {r_rad[63:0], 2'b00};
                    r_step <= r_step - 6'd1;
                    if (r_step == 6'd1) begin
                        r_state <= r_mode_tick ? S_TDT : S_RADD;
                    end
                end
                S_RADD: begin
                    r_total[r_v]   <= sum_tot[48]  ? M48 : sum_tot[47:0];
                    r_trip[r_v]    <= sum_trip[48] ? M48 : sum_trip[47:0];
                    r_changed[r_v] <= 1'b1;
                    r_known[r_v]   <= 1'b1;
                    r_state        <= S_RWR;
                end
                S_RWR: begin
                    r_head[r_v] <= head_nx;
                    r_cnt[r_v]  <= (cnt_inc > {1'b0, eff_len}) ? eff_len : cnt_inc[LW-1:0];
                    r_state     <= S_IDLE;
                end
                S_TRIP: begin
                    if (slot_free) begin
                        r_o_kind  <= KIND_TRIP;
                        r_o_track <= r_v;
                        r_o_spd   <= '0;
                        r_o_total <= '0;
                        r_o_trip  <= '0;
                        r_o_ok    <= r_known[r_v];
                        r_o_last  <= 1'b1;
                        if (r_known[r_v]) begin
                            r_trip[r_v] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_TTRK: begin
                    if (r_i == IW'(NV)) begin
                        r_i     <= '0;
                        r_state <= S_OSCAN;
                    end else if (spd_has[ti]) begin
                        r_legs  <= t_nl;
                        r_nlegs <= t_nl;
                        r_idx   <= t_idx0;
                        r_sum   <= '0;
                        r_state <= S_TLA;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_TLA: begin
                    r_a     <= r_rd;
                    r_idx   <= r_idx + 4'd1;
                    r_state <= S_TLB;
                end
                S_TLB: begin
                    r_b     <= r_rd;
                    r_state <= S_SQX;
                end
                S_TDT: begin
                    if (dt == '0) begin
                        r_spd   <= M32;
                        r_state <= S_TACC;
                    end else begin
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    r_dvd     <= prod[47:0];
                    r_dvs     <= dt;
                    r_rem     <= '0;
                    r_step    <= 6'd48;
                    r_div_avg <= 1'b0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= d_rem;
                    r_dvd  <= d_q;
                    r_step <= r_step - 6'd1;
                    if (r_step == 6'd1) begin
                        if (r_div_avg) begin
                            r_state <= S_TEMIT;
                        end else begin
                            r_spd   <= (d_q[47:32] != '0) ? M32 : d_q[31:0];
                            r_state <= S_TACC;
                        end
                    end
                end
                S_TACC: begin
                    r_sum  <= r_sum + {4'd0, r_spd};
                    r_a    <= r_b;
                    r_legs <= r_legs - 4'd1;
                    if (r_legs == 4'd1) begin
                        r_state <= S_TAVG;
                    end else begin
                        r_idx   <= r_idx + 4'd1;
                        r_state <= S_TLB;
                    end
                end
                S_TAVG: begin
                    r_dvd     <= {12'd0, r_sum};
                    r_dvs     <= {28'd0, r_nlegs};
                    r_rem     <= '0;
                    r_step    <= 6'd48;
                    r_div_avg <= 1'b1;
                    r_state   <= S_DIV;
                end
                S_TEMIT: begin
                    if (slot_free) begin
                        r_o_kind  <= KIND_SPEED;
                        r_o_track <= ti;
                        r_o_spd   <= r_dvd[31:0];
                        r_o_total <= '0;
                        r_o_trip  <= '0;
                        r_o_ok    <= 1'b0;
                        r_o_last  <= !more_spd && (r_changed == '0);
                        r_i       <= r_i + 1'b1;
                        r_state   <= S_TTRK;
                    end
                end
                S_OSCAN: begin
                    if (r_i == IW'(NV)) begin
                        r_state <= S_IDLE;
                    end else if (r_changed[ti]) begin
                        if (slot_free) begin
                            r_o_kind      <= KIND_ODO;
                            r_o_track     <= ti;
                            r_o_spd       <= '0;
                            r_o_total     <= r_total[ti];
                            r_o_trip      <= r_trip[ti];
                            r_o_ok        <= 1'b0;
                            r_o_last      <= !more_chg;
                            r_changed[ti] <= 1'b0;
                            r_i           <= r_i + 1'b1;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_kind      = r_o_kind;
    assign o_track     = r_o_track;
    assign o_mean_spd  = r_o_spd;
    assign o_odo_total = r_o_total;
    assign o_odo_trip  = r_o_trip;
    assign o_reset_ok  = r_o_ok;
    assign o_last      = r_o_last;

endmodule

// ===== rtl/mtos_check.sv =====
module mtos_check import mtos_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [2:0]  o_track,
    input logic [31:0] o_mean_spd,
    input logic [47:0] o_odo_total,
    input logic [47:0] o_odo_trip,
    input logic        o_reset_ok,
    input logic        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
            && $stable(o_track) && $stable(o_mean_spd) && $stable(o_odo_total))
        else $error("stalled transfer changed");

    a_trip_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_TRIP) |-> o_last)
        else $error("trip status not last");

    a_ok_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reset_ok |-> (o_kind == KIND_TRIP))
        else $error("reset_ok outside trip status");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted transfer did not stall input");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_SPEED) |-> (o_odo_total == '0) && (o_odo_trip == '0))
        else $error("speed report carries odometry");

endmodule

bind multi_track_odometer_speed mtos_check u_mtos_check (.*);
